[sv/utf8d_pkg.sv]
// shared types and constants for the utf-8 stream decoder
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;   // results per request, 0 to 4

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // sequence lengths held in the pending-length register
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // what one request produces: count-1 replacements, then last_cp
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CP_W-1:0]  last_cp;
    logic             text_end;
  } burst_t;

endpackage

`default_nettype wire

[sv/utf8d_decode.sv]
// sequence state and per-byte decode into a result burst
`default_nettype none

module utf8d_decode import utf8d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       text_end_i,
  output burst_t          burst_o
);

  logic [2:0]      exp_len_q, exp_len_d;
  logic [1:0]      held_q, held_d;
  logic [CP_W-1:0] acc_q, acc_d;

  logic            is_cont;
  logic [2:0]      held_inc;
  logic [2:0]      flush_cnt;
  logic [CP_W-1:0] acc_shift;
  logic            fresh;
  logic [2:0]      lead_len;
  logic [CP_W-1:0] lead_payload;
  logic [CNT_W-1:0] cnt;
  logic [CP_W-1:0] cp;

  assign is_cont   = (byte_in_i[7:6] == 2'b10);
  assign held_inc  = {1'b0, held_q} + 3'd1;
  assign acc_shift = {acc_q[CP_W-7:0], byte_in_i[5:0]};
  // replacements for the lead plus held continuations, at most three
  assign flush_cnt = (held_q == 2'd3) ? 3'd3 : held_inc;

  always_comb begin
    lead_len     = SEQ_NONE;
    lead_payload = '0;
    if (byte_in_i[7:5] == 3'b110) begin
      lead_len     = SEQ_TWO;
      lead_payload = {{(CP_W-5){1'b0}}, byte_in_i[4:0]};
    end else if (byte_in_i[7:4] == 4'b1110) begin
      lead_len     = SEQ_THREE;
      lead_payload = {{(CP_W-4){1'b0}}, byte_in_i[3:0]};
    end else if (byte_in_i[7:3] == 5'b11110) begin
      lead_len     = SEQ_FOUR;
      lead_payload = {{(CP_W-3){1'b0}}, byte_in_i[2:0]};
    end
  end

  always_comb begin
    exp_len_d = exp_len_q;
    held_d    = held_q;
    acc_d     = acc_q;
    fresh     = 1'b1;
    cnt       = '0;
    cp        = REPLACEMENT_CP;

    if (exp_len_q != SEQ_NONE) begin
      if (is_cont) begin
        fresh = 1'b0;
        if ((held_inc + 3'd1) >= exp_len_q) begin
          cnt       = 3'd1;
          cp        = acc_shift;
          exp_len_d = SEQ_NONE;
          held_d    = '0;
          acc_d     = '0;
        end else if (text_end_i) begin
          // truncated: lead plus every continuation so far, this one included
          cnt       = (held_inc == 3'd3) ? 3'd3 : held_inc + 3'd1;
          exp_len_d = SEQ_NONE;
          held_d    = '0;
          acc_d     = '0;
        end else begin
          held_d = held_inc[1:0];
          acc_d  = acc_shift;
        end
      end else begin
        // broken sequence, then this byte is decoded afresh
        cnt       = flush_cnt;
        exp_len_d = SEQ_NONE;
        held_d    = '0;
        acc_d     = '0;
      end
    end

    if (fresh) begin
      if (!byte_in_i[7]) begin
        cnt = cnt + 3'd1;
        cp  = {{(CP_W-8){1'b0}}, byte_in_i};
      end else if (lead_len == SEQ_NONE || text_end_i) begin
        cnt = cnt + 3'd1;
        cp  = REPLACEMENT_CP;
      end else begin
        exp_len_d = lead_len;
        held_d    = '0;
        acc_d     = lead_payload;
      end
    end
  end

  assign burst_o.count    = cnt;
  assign burst_o.last_cp  = cp;
  assign burst_o.text_end = text_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= SEQ_NONE;
      held_q    <= '0;
      acc_q     <= '0;
    end else if (accept_i) begin
      exp_len_q <= exp_len_d;
      held_q    <= held_d;
      acc_q     <= acc_d;
    end
  end

endmodule

`default_nettype wire

[sv/utf8_stream_decoder_core.sv]
// utf-8 byte stream to code point decoder, top level
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | byte_in_i, text_end_i
//   out     | output    | out_valid_o / out_stall_i | code_point_o, run_last_o, stream_last_o
//
// one byte is taken per cycle while in_stall_o is low; a byte that yields results
// holds the input until the burst register hands its last result to the output register.
// bytes that only extend a sequence yield nothing and cause no stall of their own.
// a result passes the burst register and then the output register before it is valid.
// reset clears sequence state and all valid flags; the output register
// holds its result while out_stall_i is high.
`default_nettype none

module utf8_stream_decoder_core import utf8d_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      byte_in_i,
  input  wire logic            text_end_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [CP_W-1:0]      code_point_o,
  output logic                 run_last_o,
  output logic                 stream_last_o
);

  burst_t           burst;
  logic             accept;

  logic             pend_valid_q, pend_valid_d;
  logic [CNT_W-1:0] pend_left_q, pend_left_d;
  logic [CP_W-1:0]  pend_cp_q;
  logic             pend_end_q;

  logic             out_valid_q;
  logic [CP_W-1:0]  out_cp_q;
  logic             out_run_q;
  logic             out_end_q;

  logic             out_ready;
  logic             pend_pop;
  logic             pend_last;

  utf8d_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .byte_in_i  (byte_in_i),
    .text_end_i (text_end_i),
    .burst_o    (burst)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign pend_pop   = pend_valid_q && out_ready;
  assign pend_last  = (pend_left_q == CNT_W'(1));
  assign in_stall_o = pend_valid_q && !(pend_pop && pend_last);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_left_d  = pend_left_q;
    if (pend_pop) begin
      pend_left_d = pend_left_q - CNT_W'(1);
      if (pend_last) begin
        pend_valid_d = 1'b0;
      end
    end
    if (accept && burst.count != '0) begin
      pend_valid_d = 1'b1;
      pend_left_d  = burst.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_left_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_left_q  <= pend_left_d;
      if (out_ready) begin
        out_valid_q <= pend_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && burst.count != '0) begin
      pend_cp_q  <= burst.last_cp;
      pend_end_q <= burst.text_end;
    end
    if (pend_pop) begin
      // replacements lead the burst, the byte's own result closes it
      out_cp_q  <= pend_last ? pend_cp_q : REPLACEMENT_CP;
      out_run_q <= pend_last;
      out_end_q <= pend_last && pend_end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_cp_q;
  assign run_last_o    = out_run_q;
  assign stream_last_o = out_end_q;

endmodule

`default_nettype wire
